// ----- src/rsgp_pkg.sv -----
// rsgp_pkg: shared constants, types and GF(2^w) arithmetic for the
// generator polynomial builder. No dependencies; used by the top level
// and by its checker.
package rsgp_pkg;

    localparam int MAX_DEGREE_DEF = 32;

    // stream payload widths
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int CFG_DATA_W = 9;

    // register indexes on the config port
    localparam logic REG_FIELD_WIDTH = 1'b0;
    localparam logic REG_FIELD_POLY  = 1'b1;

    localparam logic [3:0] FIELD_WIDTH_RST = 4'd8;
    localparam logic [8:0] FIELD_POLY_RST  = 9'h11D;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUILD = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    // clamp the field width to 2..8
    function automatic logic [3:0] eff_width(input logic [3:0] fw);
        logic [3:0] w;
        w = fw;
        if (fw < 4'd2) w = 4'd2;
        if (fw > 4'd8) w = 4'd8;
        return w;
    endfunction

    function automatic logic [8:0] width_mask(input logic [3:0] w);
        return (9'd1 << w) - 9'd1;
    endfunction

    // multiply by x and reduce
    function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [3:0] w,
                                            input logic [8:0] poly);
        logic [8:0] t;
        t = {a, 1'b0};
        if (t[w]) t = t ^ poly;
        return 8'(t & width_mask(w));
    endfunction

    // shift-and-add product, one partial term per bit of b
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [3:0] w, input logic [8:0] poly);
        logic [7:0] m;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] acc;
        m   = 8'(width_mask(w));
        x   = a & m;
        y   = b & m;
        acc = 8'd0;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) acc = acc ^ x;
            x = gf_xtime(x, w, poly);
        end
        return acc & m;
    endfunction

endpackage

// ----- src/rs_generator_polynomial.sv -----
// rs_generator_polynomial: builds and streams the Reed-Solomon generator
// polynomial over GF(2^w) from a parity count.
// Depends on rsgp_pkg.

// One beat on the slave side carries a parity count n (saturated to
// MAX_DEGREE); the block then streams the n+1 coefficients of
// g(x) = (x+a^0)(x+a^1)...(x+a^(n-1)), constant term first, with tlast on
// the top one. The coefficients live in a single-port-write, registered-read
// memory and one shared GF multiplier walks it once per linear factor, top
// entry first, and a closing step ends the build. The output issues one
// memory read and loads its data into the output register before it issues
// the next, and reads only when that register will be empty. A new parity
// count is taken once the last coefficient sits in the output register. The
// user must write field width and reduction polynomial on the config port
// only while the block is idle; the block itself does not enforce this.
module rs_generator_polynomial
    import rsgp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [5:0] parity_count
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [5:0] coeff_index, [13:6] coeff_value
    output logic                  o_m_axis_tlast
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [3:0]    r_fw;
    logic [8:0]    r_poly;
    logic [AW-1:0] r_n, n_n;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_s, n_s;
    logic [7:0]    r_root, n_root;
    logic [7:0]    r_hi, n_hi;
    logic [AW-1:0] r_j, n_j;
    logic [AW-1:0] r_pend_idx, n_pend_idx;
    logic          r_rd_pend, n_rd_pend;
    logic          r_out_valid, n_out_valid;
    logic [5:0]    r_out_idx, n_out_idx;
    logic [7:0]    r_out_val, n_out_val;
    logic          r_out_last, n_out_last;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_rd_data;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    logic [3:0]    w_eff;
    logic [7:0]    mul_res;
    logic [5:0]    in_pc;
    logic [AW-1:0] in_n;
    logic          in_acc;
    logic          out_free;
    logic          last_step;
    logic          last_factor;
    logic [AW:0]   build_wr_addr;

    assign w_eff   = eff_width(r_fw);
    assign mul_res = gf_mul(r_hi, r_root, w_eff, r_poly);

    assign in_pc  = i_s_axis_tdata[5:0];
    assign in_n   = (in_pc > 6'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : in_pc[AW-1:0];
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign out_free      = !r_out_valid || i_m_axis_tready;
    assign last_step     = ({1'b0, r_s} == ({1'b0, r_k} + 1'b1));
    assign last_factor   = (({1'b0, r_k} + 1'b1) == {1'b0, r_n});
    // new[k-s+2] is formed from old[k-s+1], read by the previous step
    assign build_wr_addr = {1'b0, r_k} - {1'b0, r_s} + (AW+1)'(2);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_s         = r_s;
        n_root      = r_root;
        n_hi        = r_hi;
        n_j         = r_j;
        n_pend_idx  = r_pend_idx;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_val   = r_out_val;
        n_out_last  = r_out_last;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = 8'd0;

        if (r_out_valid && i_m_axis_tready) n_out_valid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    // g = 1 before any factor
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = 8'd1;
                    n_n     = in_n;
                    n_k     = '0;
                    n_s     = '0;
                    n_j     = '0;
                    n_root  = 8'd1;
                    n_hi    = 8'd0;
                    n_state = (in_n == '0) ? ST_OUT : ST_BUILD;
                end
            end
            ST_BUILD: begin
                if (r_s == '0) begin
                    // close the previous factor at entry zero, then step the root
                    if (r_k != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = mul_res;
                        n_root  = gf_xtime(r_root, w_eff, r_poly);
                    end
                    n_hi = 8'd0;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = build_wr_addr[AW-1:0];
                    wr_data = r_rd_data ^ mul_res;
                    n_hi    = r_rd_data;
                end
                if (r_s <= r_k) begin
                    rd_en   = 1'b1;
                    rd_addr = r_k - r_s;
                end
                if (last_step) begin
                    n_s = '0;
                    if (last_factor) n_state = ST_DRAIN;
                    else             n_k = r_k + 1'b1;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            ST_DRAIN: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = mul_res;
                n_root  = gf_xtime(r_root, w_eff, r_poly);
                n_j     = '0;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (r_rd_pend) begin
                    n_rd_pend   = 1'b0;
                    n_out_valid = 1'b1;
                    n_out_idx   = 6'(r_pend_idx);
                    n_out_val   = r_rd_data;
                    n_out_last  = (r_pend_idx == r_n);
                    if (r_pend_idx == r_n) n_state = ST_IDLE;
                end else if (out_free) begin
                    // issue only when the output register will be empty
                    rd_en      = 1'b1;
                    rd_addr    = r_j;
                    n_pend_idx = r_j;
                    n_j        = r_j + 1'b1;
                    n_rd_pend  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fw        <= FIELD_WIDTH_RST;
            r_poly      <= FIELD_POLY_RST;
            r_n         <= '0;
            r_k         <= '0;
            r_s         <= '0;
            r_root      <= 8'd1;
            r_j         <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_k         <= n_k;
            r_s         <= n_s;
            r_root      <= n_root;
            r_j         <= n_j;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_FIELD_WIDTH: r_fw   <= i_cfg_data[3:0];
                    REG_FIELD_POLY:  r_poly <= i_cfg_data[8:0];
                    default:         r_poly <= r_poly;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_pend_idx <= n_pend_idx;
        r_out_idx  <= n_out_idx;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_val, r_out_idx};
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- src/rsgp_checker.sv -----
// rsgp_checker: port-level assertions for rs_generator_polynomial, and the
// bind that attaches them. Depends on rsgp_pkg.
module rsgp_checker
    import rsgp_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 i_s_tready,
    input logic                 i_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] i_m_tdata,
    input logic                 i_m_tlast
);

    logic [5:0] r_exp_idx;

    // coefficient index expected on the next output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= 6'd0;
        end else if (i_m_tvalid && i_m_tready) begin
            r_exp_idx <= i_m_tlast ? 6'd0 : r_exp_idx + 6'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("output beat changed while stalled");

    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[5:0] == r_exp_idx)
        else $error("coefficient index out of sequence");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> i_m_tdata[5:0] <= 6'(MAX_DEGREE))
        else $error("coefficient index above maximum degree");

    a_monic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tdata[13:6] == 8'd1)
        else $error("top coefficient is not one");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input taken again right after a beat");

endmodule

bind rs_generator_polynomial rsgp_checker #(
    .MAX_DEGREE (MAX_DEGREE)
) u_rsgp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tlast  (o_m_axis_tlast)
);
